// ===== hw/rtl/scs_pkg.sv =====
`timescale 1ns / 1ps

package scs_pkg;

    localparam int PULSE_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 48;

    localparam int MOTOR_W   = 12;
    localparam int BOUND_W   = 12;
    localparam int PCT_W     = 8;
    localparam int MASK_W    = 6;
    localparam int LINK_W    = 8;
    localparam int TIMEOUT_W = 48;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 9;
    localparam int RSTEP_W   = 10;
    localparam int FSTART_W  = 12;
    localparam int RSTART_W  = 11;
    localparam int NUM_W     = 21;
    localparam int SAT_W     = 17;

    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 32;
    localparam int QUO_W       = NUM_W - 1 + RECIP_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP = 26'd42949673;

    localparam logic [MOTOR_W-1:0] NEUTRAL = 12'd1500;
    localparam logic signed [PCT_W-1:0] PCT_MAX = 8'sd100;
    localparam logic signed [PCT_W-1:0] PCT_MIN = -8'sd100;

    localparam logic FUNC_COMMAND = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    localparam int MASK_MOTOR = 0;
    localparam int MASK_RUDDER = 1;
    localparam int MASK_STBD = 2;
    localparam int MASK_PORT = 3;
    localparam int MASK_LINK = 4;
    localparam int MASK_LED = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOTOR_STEP     = 3'd0,
        CFG_MOTOR_RSTEP    = 3'd1,
        CFG_FORWARD_START  = 3'd2,
        CFG_REVERSE_START  = 3'd3,
        CFG_TIMEOUT        = 3'd4,
        CFG_RUDDER_BOUNDS  = 3'd5,
        CFG_STBD_BOUNDS    = 3'd6,
        CFG_PORT_BOUNDS    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [BOUND_W-1:0] upper;
        logic [BOUND_W-1:0] center;
        logic [BOUND_W-1:0] lower;
    } bounds_t;

    typedef struct packed {
        logic [STEP_W-1:0]   step;
        logic [RSTEP_W-1:0]  reverse_step;
        logic [FSTART_W-1:0] forward_start;
        logic [RSTART_W-1:0] reverse_start;
    } motor_cfg_t;

    localparam logic [STEP_W-1:0]    MOTOR_STEP_RST  = 9'd20;
    localparam logic [RSTEP_W-1:0]   MOTOR_RSTEP_RST = 10'd100;
    localparam logic [FSTART_W-1:0]  FSTART_RST      = 12'd1500;
    localparam logic [RSTART_W-1:0]  RSTART_RST      = 11'd1500;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST     = 48'd5000000;
    localparam bounds_t BOUNDS_RST = '{upper: 12'd1900, center: 12'd1500, lower: 12'd1100};
    localparam logic signed [NUM_W-1:0] NUM_RST = 21'sd150000;
    localparam logic [LINK_W-1:0] LINK_RST = 8'd5;

    function automatic logic signed [PCT_W-1:0] pct_sat(input logic signed [PCT_W-1:0] p);
        logic signed [PCT_W-1:0] r;
        r = p;
        if (p > PCT_MAX)
        begin
            r = PCT_MAX;
        end
        else if (p < PCT_MIN)
        begin
            r = PCT_MIN;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/scs_in_if.sv =====
`timescale 1ns / 1ps

interface scs_in_if #(
    parameter int TIME_BITS = scs_pkg::TIME_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic [TIME_BITS-1:0]              now_us;
    logic [scs_pkg::MASK_W-1:0]        present_mask;
    logic signed [scs_pkg::PCT_W-1:0]  motor_percent;
    logic signed [scs_pkg::PCT_W-1:0]  rudder_percent;
    logic signed [scs_pkg::PCT_W-1:0]  starboard_percent;
    logic signed [scs_pkg::PCT_W-1:0]  port_percent;
    logic [scs_pkg::LINK_W-1:0]        link_timeout_in;
    logic                              led_in;

    modport source (
        output valid, func, now_us, present_mask, motor_percent, rudder_percent,
               starboard_percent, port_percent, link_timeout_in, led_in,
        input  ready
    );

    modport sink (
        input  valid, func, now_us, present_mask, motor_percent, rudder_percent,
               starboard_percent, port_percent, link_timeout_in, led_in,
        output ready
    );
endinterface

// ===== hw/rtl/scs_out_if.sv =====
`timescale 1ns / 1ps

interface scs_out_if #(
    parameter int PULSE_BITS = scs_pkg::PULSE_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [PULSE_BITS-1:0]       motor_pulse;
    logic [PULSE_BITS-1:0]       rudder_pulse;
    logic [PULSE_BITS-1:0]       starboard_pulse;
    logic [PULSE_BITS-1:0]       port_pulse;
    logic [scs_pkg::LINK_W-1:0]  link_timeout_out;
    logic                        led_out;
    logic                        timed_out;

    modport source (
        output valid, motor_pulse, rudder_pulse, starboard_pulse, port_pulse,
               link_timeout_out, led_out, timed_out,
        input  ready
    );

    modport sink (
        input  valid, motor_pulse, rudder_pulse, starboard_pulse, port_pulse,
               link_timeout_out, led_out, timed_out,
        output ready
    );
endinterface

// ===== hw/rtl/scs_surface.sv =====
`timescale 1ns / 1ps

module scs_surface (
    input  logic signed [scs_pkg::PCT_W-1:0] pct,
    input  scs_pkg::bounds_t                 bounds,
    output logic signed [scs_pkg::NUM_W-1:0] num
);
    logic signed [scs_pkg::BOUND_W:0]   span;
    logic signed [scs_pkg::NUM_W-1:0]   prod;
    logic [scs_pkg::NUM_W-2:0]          center_x100;
    logic                               pct_pos;

    assign pct_pos = !pct[scs_pkg::PCT_W-1] && (pct != '0);

    assign span = pct_pos
        ? $signed({1'b0, bounds.upper}) - $signed({1'b0, bounds.center})
        : $signed({1'b0, bounds.center}) - $signed({1'b0, bounds.lower});

    assign prod = scs_pkg::NUM_W'(pct) * scs_pkg::NUM_W'(span);

    // 100 * center as 64 + 32 + 4
    assign center_x100 = {2'b00, bounds.center, 6'b0}
                       + {3'b000, bounds.center, 5'b0}
                       + {6'b000000, bounds.center, 2'b0};

    assign num = $signed({1'b0, center_x100}) + prod;
endmodule

// ===== hw/rtl/scs_scale.sv =====
`timescale 1ns / 1ps

module scs_scale #(
    parameter int PULSE_BITS = scs_pkg::PULSE_BITS_DEF
) (
    input  logic signed [scs_pkg::NUM_W-1:0] num,
    output logic [PULSE_BITS-1:0]            pulse
);
    localparam int PROD_W = scs_pkg::NUM_W - 1 + scs_pkg::RECIP_W;
    localparam logic [scs_pkg::SAT_W-1:0] PULSE_MAX = scs_pkg::SAT_W'((1 << PULSE_BITS) - 1);

    logic [PROD_W-1:0]          prod;
    logic [scs_pkg::QUO_W-1:0]  quo;
    logic [scs_pkg::SAT_W-1:0]  quo_x;
    logic [scs_pkg::SAT_W-1:0]  sat;

    // floor(num / 100) by reciprocal, exact over the whole non-negative range
    assign prod  = PROD_W'(num[scs_pkg::NUM_W-2:0]) * PROD_W'(scs_pkg::RECIP);
    assign quo   = prod[PROD_W-1:scs_pkg::RECIP_SHIFT];
    assign quo_x = scs_pkg::SAT_W'(quo);

    always_comb
    begin
        if (num[scs_pkg::NUM_W-1])
        begin
            sat = '0;
        end
        else if (quo_x > PULSE_MAX)
        begin
            sat = PULSE_MAX;
        end
        else
        begin
            sat = quo_x;
        end
    end

    assign pulse = sat[PULSE_BITS-1:0];
endmodule

// ===== hw/rtl/scs_motor.sv =====
`timescale 1ns / 1ps

module scs_motor #(
    parameter int PULSE_BITS = scs_pkg::PULSE_BITS_DEF
) (
    input  logic [scs_pkg::MOTOR_W-1:0] target,
    input  logic [scs_pkg::MOTOR_W-1:0] current,
    input  scs_pkg::motor_cfg_t         cfg,
    output logic [scs_pkg::MOTOR_W-1:0] current_next,
    output logic [PULSE_BITS-1:0]       pulse
);
    localparam logic [scs_pkg::SAT_W-1:0] PULSE_MAX = scs_pkg::SAT_W'((1 << PULSE_BITS) - 1);

    logic                         rising;
    logic [scs_pkg::MOTOR_W-1:0]  diff_up;
    logic [scs_pkg::MOTOR_W-1:0]  diff_dn;
    logic [scs_pkg::MOTOR_W-1:0]  step_fwd;
    logic [scs_pkg::MOTOR_W-1:0]  step_rev;
    logic [scs_pkg::MOTOR_W-1:0]  step_up;
    logic [scs_pkg::MOTOR_W-1:0]  step_dn;
    logic [scs_pkg::MOTOR_W-1:0]  delta_up;
    logic [scs_pkg::MOTOR_W-1:0]  delta_dn;
    logic [scs_pkg::MOTOR_W-1:0]  rstart_x;
    logic [scs_pkg::MOTOR_W-1:0]  banded;
    logic [scs_pkg::SAT_W-1:0]    banded_x;
    logic [scs_pkg::SAT_W-1:0]    sat;

    assign rising   = target > current;
    assign diff_up  = target - current;
    assign diff_dn  = current - target;
    assign step_fwd = scs_pkg::MOTOR_W'(cfg.step);
    assign step_rev = scs_pkg::MOTOR_W'(cfg.reverse_step);
    assign step_up  = (current >= scs_pkg::NEUTRAL) ? step_fwd : step_rev;
    assign step_dn  = (current <= scs_pkg::NEUTRAL) ? step_fwd : step_rev;
    assign delta_up = (diff_up < step_up) ? diff_up : step_up;
    assign delta_dn = (diff_dn < step_dn) ? diff_dn : step_dn;

    assign current_next = rising ? current + delta_up : current - delta_dn;

    assign rstart_x = scs_pkg::MOTOR_W'(cfg.reverse_start);

    always_comb
    begin
        if (current_next > scs_pkg::NEUTRAL && current_next < cfg.forward_start)
        begin
            banded = cfg.forward_start;
        end
        else if (current_next < scs_pkg::NEUTRAL && current_next > rstart_x)
        begin
            banded = rstart_x;
        end
        else
        begin
            banded = current_next;
        end
    end

    assign banded_x = scs_pkg::SAT_W'(banded);
    assign sat      = (banded_x > PULSE_MAX) ? PULSE_MAX : banded_x;
    assign pulse    = sat[PULSE_BITS-1:0];
endmodule

// ===== hw/rtl/servo_command_shaper.sv =====
`timescale 1ns / 1ps

// Channel  | Dir | Handshake         | Beat
// ---------+-----+-------------------+---------------------------------------
// item     | in  | valid/ready       | command update (func 0) or tick (func 1)
// result   | out | valid/ready       | pulse widths, link timeout, led, timed_out
// cfg      | in  | cfg_we, no stall  | register index and data
//
// One item per cycle while no tick is held by a stalled result. An item is held in the input register; a tick's
// beat is loaded into the result register as the tick leaves the input register.
// A command updates state as it leaves the input register and yields no beat.
// A stalled result holds a tick in the input register, which stalls the input;
// commands keep flowing past a stalled result.
// Reset clears both valid flags and loads configuration and state.

module servo_command_shaper #(
    parameter int PULSE_BITS = scs_pkg::PULSE_BITS_DEF,
    parameter int TIME_BITS  = scs_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [scs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scs_pkg::CFG_W-1:0]       cfg_data,
    scs_in_if.sink                          item,
    scs_out_if.source                       result
);
    localparam int CMP_W = (TIME_BITS > scs_pkg::TIMEOUT_W) ? TIME_BITS : scs_pkg::TIMEOUT_W;

    // configuration
    scs_pkg::motor_cfg_t               motor_cfg_reg;
    logic [scs_pkg::TIMEOUT_W-1:0]     timeout_reg;
    scs_pkg::bounds_t                  rudder_bounds_reg;
    scs_pkg::bounds_t                  stbd_bounds_reg;
    scs_pkg::bounds_t                  port_bounds_reg;

    // block state
    logic [scs_pkg::MOTOR_W-1:0]       target_reg;
    logic [scs_pkg::MOTOR_W-1:0]       current_reg;
    logic signed [scs_pkg::NUM_W-1:0]  rudder_num_reg;
    logic signed [scs_pkg::NUM_W-1:0]  stbd_num_reg;
    logic signed [scs_pkg::NUM_W-1:0]  port_num_reg;
    logic [scs_pkg::LINK_W-1:0]        link_reg;
    logic                              led_reg;
    logic [TIME_BITS-1:0]              last_time_reg;
    logic                              seen_reg;

    // input register
    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    logic                              s1_func_reg;
    logic [TIME_BITS-1:0]              s1_now_reg;
    logic [scs_pkg::MASK_W-1:0]        s1_mask_reg;
    logic signed [scs_pkg::PCT_W-1:0]  s1_motor_pct_reg;
    logic signed [scs_pkg::PCT_W-1:0]  s1_rudder_pct_reg;
    logic signed [scs_pkg::PCT_W-1:0]  s1_stbd_pct_reg;
    logic signed [scs_pkg::PCT_W-1:0]  s1_port_pct_reg;
    logic [scs_pkg::LINK_W-1:0]        s1_link_reg;
    logic                              s1_led_reg;

    // result register
    logic                              res_valid_reg;
    logic                              res_valid_next;
    logic [PULSE_BITS-1:0]             res_motor_reg;
    logic [PULSE_BITS-1:0]             res_rudder_reg;
    logic [PULSE_BITS-1:0]             res_stbd_reg;
    logic [PULSE_BITS-1:0]             res_port_reg;
    logic [scs_pkg::LINK_W-1:0]        res_link_reg;
    logic                              res_led_reg;
    logic                              res_timed_out_reg;

    logic                              in_take;
    logic                              is_tick;
    logic                              advance;
    logic                              stale;
    logic [TIME_BITS-1:0]              age;

    logic signed [scs_pkg::PCT_W-1:0]  motor_pct;
    logic signed [scs_pkg::PCT_W+1:0]  motor_pct_x4;
    logic signed [scs_pkg::MOTOR_W:0]  target_wide;
    logic signed [scs_pkg::NUM_W-1:0]  rudder_num;
    logic signed [scs_pkg::NUM_W-1:0]  stbd_num;
    logic signed [scs_pkg::NUM_W-1:0]  port_num;

    logic [scs_pkg::MOTOR_W-1:0]       current_next;
    logic [PULSE_BITS-1:0]             motor_pulse;
    logic [PULSE_BITS-1:0]             rudder_pulse;
    logic [PULSE_BITS-1:0]             stbd_pulse;
    logic [PULSE_BITS-1:0]             port_pulse;

    logic [scs_pkg::SAT_W-1:0]         neutral_x;
    logic [scs_pkg::SAT_W-1:0]         rudder_center_x;
    logic [scs_pkg::SAT_W-1:0]         stbd_center_x;
    logic [scs_pkg::SAT_W-1:0]         port_center_x;

    // handshake
    assign is_tick    = (s1_func_reg == scs_pkg::FUNC_TICK);
    assign advance    = s1_valid_reg && (!is_tick || !res_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign in_take    = item.valid && item.ready;

    assign s1_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign res_valid_next = (advance && is_tick) ? 1'b1
                          : (result.ready ? 1'b0 : res_valid_reg);

    // command path
    assign motor_pct    = scs_pkg::pct_sat(s1_motor_pct_reg);
    assign motor_pct_x4 = {motor_pct, 2'b00};
    assign target_wide  = $signed({1'b0, scs_pkg::NEUTRAL}) + motor_pct_x4;

    scs_surface u_rudder_surf (
        .pct    (scs_pkg::pct_sat(s1_rudder_pct_reg)),
        .bounds (rudder_bounds_reg),
        .num    (rudder_num)
    );

    scs_surface u_stbd_surf (
        .pct    (scs_pkg::pct_sat(s1_stbd_pct_reg)),
        .bounds (stbd_bounds_reg),
        .num    (stbd_num)
    );

    scs_surface u_port_surf (
        .pct    (scs_pkg::pct_sat(s1_port_pct_reg)),
        .bounds (port_bounds_reg),
        .num    (port_num)
    );

    // tick path
    assign age   = s1_now_reg - last_time_reg;
    assign stale = seen_reg && (CMP_W'(age) > CMP_W'(timeout_reg));

    scs_motor #(
        .PULSE_BITS (PULSE_BITS)
    ) u_motor (
        .target       (target_reg),
        .current      (current_reg),
        .cfg          (motor_cfg_reg),
        .current_next (current_next),
        .pulse        (motor_pulse)
    );

    scs_scale #(
        .PULSE_BITS (PULSE_BITS)
    ) u_rudder_scale (
        .num   (rudder_num_reg),
        .pulse (rudder_pulse)
    );

    scs_scale #(
        .PULSE_BITS (PULSE_BITS)
    ) u_stbd_scale (
        .num   (stbd_num_reg),
        .pulse (stbd_pulse)
    );

    scs_scale #(
        .PULSE_BITS (PULSE_BITS)
    ) u_port_scale (
        .num   (port_num_reg),
        .pulse (port_pulse)
    );

    assign neutral_x       = scs_pkg::SAT_W'(scs_pkg::NEUTRAL);
    assign rudder_center_x = scs_pkg::SAT_W'(rudder_bounds_reg.center);
    assign stbd_center_x   = scs_pkg::SAT_W'(stbd_bounds_reg.center);
    assign port_center_x   = scs_pkg::SAT_W'(port_bounds_reg.center);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_cfg_reg.step          <= scs_pkg::MOTOR_STEP_RST;
            motor_cfg_reg.reverse_step  <= scs_pkg::MOTOR_RSTEP_RST;
            motor_cfg_reg.forward_start <= scs_pkg::FSTART_RST;
            motor_cfg_reg.reverse_start <= scs_pkg::RSTART_RST;
            timeout_reg                 <= scs_pkg::TIMEOUT_RST;
            rudder_bounds_reg           <= scs_pkg::BOUNDS_RST;
            stbd_bounds_reg             <= scs_pkg::BOUNDS_RST;
            port_bounds_reg             <= scs_pkg::BOUNDS_RST;
        end
        else if (cfg_we)
        begin
            case (scs_pkg::cfg_index_t'(cfg_index))
                scs_pkg::CFG_MOTOR_STEP:
                    motor_cfg_reg.step <= cfg_data[scs_pkg::STEP_W-1:0];
                scs_pkg::CFG_MOTOR_RSTEP:
                    motor_cfg_reg.reverse_step <= cfg_data[scs_pkg::RSTEP_W-1:0];
                scs_pkg::CFG_FORWARD_START:
                    motor_cfg_reg.forward_start <= cfg_data[scs_pkg::FSTART_W-1:0];
                scs_pkg::CFG_REVERSE_START:
                    motor_cfg_reg.reverse_start <= cfg_data[scs_pkg::RSTART_W-1:0];
                scs_pkg::CFG_TIMEOUT:
                    timeout_reg <= cfg_data[scs_pkg::TIMEOUT_W-1:0];
                scs_pkg::CFG_RUDDER_BOUNDS:
                    rudder_bounds_reg <= scs_pkg::bounds_t'(cfg_data[3*scs_pkg::BOUND_W-1:0]);
                scs_pkg::CFG_STBD_BOUNDS:
                    stbd_bounds_reg <= scs_pkg::bounds_t'(cfg_data[3*scs_pkg::BOUND_W-1:0]);
                scs_pkg::CFG_PORT_BOUNDS:
                    port_bounds_reg <= scs_pkg::bounds_t'(cfg_data[3*scs_pkg::BOUND_W-1:0]);
                default:
                    timeout_reg <= timeout_reg;
            endcase
        end
    end

    // block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= scs_pkg::NEUTRAL;
            current_reg    <= scs_pkg::NEUTRAL;
            rudder_num_reg <= scs_pkg::NUM_RST;
            stbd_num_reg   <= scs_pkg::NUM_RST;
            port_num_reg   <= scs_pkg::NUM_RST;
            link_reg       <= scs_pkg::LINK_RST;
            led_reg        <= 1'b1;
            last_time_reg  <= '0;
            seen_reg       <= 1'b0;
        end
        else if (advance)
        begin
            if (!is_tick)
            begin
                if (s1_mask_reg[scs_pkg::MASK_MOTOR])
                begin
                    target_reg <= target_wide[scs_pkg::MOTOR_W-1:0];
                end
                if (s1_mask_reg[scs_pkg::MASK_RUDDER])
                begin
                    rudder_num_reg <= rudder_num;
                end
                if (s1_mask_reg[scs_pkg::MASK_STBD])
                begin
                    stbd_num_reg <= stbd_num;
                end
                if (s1_mask_reg[scs_pkg::MASK_PORT])
                begin
                    port_num_reg <= port_num;
                end
                if (s1_mask_reg[scs_pkg::MASK_LINK])
                begin
                    link_reg <= s1_link_reg;
                end
                if (s1_mask_reg[scs_pkg::MASK_LED])
                begin
                    led_reg <= s1_led_reg;
                end
                last_time_reg <= s1_now_reg;
                seen_reg      <= 1'b1;
            end
            else if (!stale)
            begin
                current_reg <= current_next;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg       <= item.func;
            s1_now_reg        <= item.now_us;
            s1_mask_reg       <= item.present_mask;
            s1_motor_pct_reg  <= item.motor_percent;
            s1_rudder_pct_reg <= item.rudder_percent;
            s1_stbd_pct_reg   <= item.starboard_percent;
            s1_port_pct_reg   <= item.port_percent;
            s1_link_reg       <= item.link_timeout_in;
            s1_led_reg        <= item.led_in;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_tick)
        begin
            res_link_reg <= link_reg;
            if (stale)
            begin
                res_motor_reg     <= neutral_x[PULSE_BITS-1:0];
                res_rudder_reg    <= rudder_center_x[PULSE_BITS-1:0];
                res_stbd_reg      <= stbd_center_x[PULSE_BITS-1:0];
                res_port_reg      <= port_center_x[PULSE_BITS-1:0];
                res_led_reg       <= 1'b0;
                res_timed_out_reg <= 1'b1;
            end
            else
            begin
                res_motor_reg     <= motor_pulse;
                res_rudder_reg    <= rudder_pulse;
                res_stbd_reg      <= stbd_pulse;
                res_port_reg      <= port_pulse;
                res_led_reg       <= led_reg;
                res_timed_out_reg <= 1'b0;
            end
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.motor_pulse      = res_motor_reg;
    assign result.rudder_pulse     = res_rudder_reg;
    assign result.starboard_pulse  = res_stbd_reg;
    assign result.port_pulse       = res_port_reg;
    assign result.link_timeout_out = res_link_reg;
    assign result.led_out          = res_led_reg;
    assign result.timed_out        = res_timed_out_reg;
endmodule

// ===== dv/servo_command_shaper_test.sv =====
`timescale 1ns / 1ps

localparam int NEUTRAL_PULSE = 1500;
localparam int PULSE_CEIL = 4095;

typedef struct packed {
    logic                                  func;
    logic [scs_pkg::TIMEOUT_W-1:0]         now_us;
    logic [scs_pkg::MASK_W-1:0]            present_mask;
    logic signed [scs_pkg::PCT_W-1:0]      motor_pct;
    logic signed [scs_pkg::PCT_W-1:0]      rudder_pct;
    logic signed [scs_pkg::PCT_W-1:0]      stbd_pct;
    logic signed [scs_pkg::PCT_W-1:0]      port_pct;
    logic [scs_pkg::LINK_W-1:0]            link_timeout;
    logic                                  led;
} shaper_item_t;

typedef struct packed {
    logic [scs_pkg::MOTOR_W-1:0]  motor;
    logic [scs_pkg::MOTOR_W-1:0]  rudder;
    logic [scs_pkg::MOTOR_W-1:0]  stbd;
    logic [scs_pkg::MOTOR_W-1:0]  port;
    logic [scs_pkg::LINK_W-1:0]   link_timeout;
    logic                         led;
    logic                         timed_out;
} shaper_beat_t;

class shaper_scoreboard;
    int motor_step;
    int reverse_step;
    int forward_start;
    int reverse_start;
    logic [scs_pkg::TIMEOUT_W-1:0] timeout_us;
    logic [35:0] bounds [3];

    int motor_target;
    int motor_now;
    int surface_pulse [3];
    logic [scs_pkg::LINK_W-1:0] link_value;
    logic led_value;
    logic [scs_pkg::TIMEOUT_W-1:0] last_cmd_us;
    bit cmd_seen;

    shaper_beat_t expected_beats[$];
    int errors;

    function new();
        motor_step = 20;
        reverse_step = 100;
        forward_start = 1500;
        reverse_start = 1500;
        timeout_us = 48'd5000000;
        for (int i = 0; i < 3; i++)
        begin
            bounds[i] = {12'd1900, 12'd1500, 12'd1100};
            surface_pulse[i] = NEUTRAL_PULSE;
        end
        motor_target = NEUTRAL_PULSE;
        motor_now = NEUTRAL_PULSE;
        link_value = 8'd5;
        led_value = 1'b1;
        last_cmd_us = '0;
        cmd_seen = 1'b0;
        errors = 0;
    endfunction

    function void write_reg(scs_pkg::cfg_index_t idx, logic [scs_pkg::CFG_W-1:0] data);
        case (idx)
            scs_pkg::CFG_MOTOR_STEP:    motor_step = int'(data[8:0]);
            scs_pkg::CFG_MOTOR_RSTEP:   reverse_step = int'(data[9:0]);
            scs_pkg::CFG_FORWARD_START: forward_start = int'(data[11:0]);
            scs_pkg::CFG_REVERSE_START: reverse_start = int'(data[10:0]);
            scs_pkg::CFG_TIMEOUT:       timeout_us = data[47:0];
            scs_pkg::CFG_RUDDER_BOUNDS: bounds[0] = data[35:0];
            scs_pkg::CFG_STBD_BOUNDS:   bounds[1] = data[35:0];
            scs_pkg::CFG_PORT_BOUNDS:   bounds[2] = data[35:0];
            default:;
        endcase
    endfunction

    function int clamp_pct(logic signed [7:0] p);
        int v;
        v = int'(p);
        if (v > 100)
            v = 100;
        if (v < -100)
            v = -100;
        return v;
    endfunction

    function int surface_of(int pct, logic [35:0] b);
        longint lower;
        longint center;
        longint upper;
        longint span;
        longint num;
        longint q;
        lower = longint'(b[11:0]);
        center = longint'(b[23:12]);
        upper = longint'(b[35:24]);
        span = (pct > 0) ? upper - center : center - lower;
        num = 100 * center + longint'(pct) * span;
        q = num / 100;
        if (num % 100 != 0 && num < 0)
            q = q - 1;
        if (q < 0)
            q = 0;
        if (q > PULSE_CEIL)
            q = PULSE_CEIL;
        return int'(q);
    endfunction

    function void note_item(shaper_item_t it);
        shaper_beat_t b;
        logic [scs_pkg::TIMEOUT_W-1:0] age;
        int gap;
        int diff;
        int m;
        if (it.func == scs_pkg::FUNC_COMMAND)
        begin
            if (it.present_mask[scs_pkg::MASK_MOTOR])
                motor_target = NEUTRAL_PULSE + 4 * clamp_pct(it.motor_pct);
            if (it.present_mask[scs_pkg::MASK_RUDDER])
                surface_pulse[0] = surface_of(clamp_pct(it.rudder_pct), bounds[0]);
            if (it.present_mask[scs_pkg::MASK_STBD])
                surface_pulse[1] = surface_of(clamp_pct(it.stbd_pct), bounds[1]);
            if (it.present_mask[scs_pkg::MASK_PORT])
                surface_pulse[2] = surface_of(clamp_pct(it.port_pct), bounds[2]);
            if (it.present_mask[scs_pkg::MASK_LINK])
                link_value = it.link_timeout;
            if (it.present_mask[scs_pkg::MASK_LED])
                led_value = it.led;
            last_cmd_us = it.now_us;
            cmd_seen = 1'b1;
            return;
        end
        age = it.now_us - last_cmd_us;
        b.link_timeout = link_value;
        if (cmd_seen && age > timeout_us)
        begin
            b.motor = 12'(NEUTRAL_PULSE);
            b.rudder = bounds[0][23:12];
            b.stbd = bounds[1][23:12];
            b.port = bounds[2][23:12];
            b.led = 1'b0;
            b.timed_out = 1'b1;
        end
        else
        begin
            if (motor_target > motor_now)
            begin
                gap = (motor_now >= NEUTRAL_PULSE) ? motor_step : reverse_step;
                diff = motor_target - motor_now;
                motor_now += (diff < gap) ? diff : gap;
            end
            else
            begin
                gap = (motor_now <= NEUTRAL_PULSE) ? motor_step : reverse_step;
                diff = motor_now - motor_target;
                motor_now -= (diff < gap) ? diff : gap;
            end
            m = motor_now;
            if (m > NEUTRAL_PULSE && m < forward_start)
                m = forward_start;
            if (m < NEUTRAL_PULSE && m > reverse_start)
                m = reverse_start;
            if (m < 0)
                m = 0;
            if (m > PULSE_CEIL)
                m = PULSE_CEIL;
            b.motor = 12'(m);
            b.rudder = 12'(surface_pulse[0]);
            b.stbd = 12'(surface_pulse[1]);
            b.port = 12'(surface_pulse[2]);
            b.led = led_value;
            b.timed_out = 1'b0;
        end
        expected_beats.push_back(b);
    endfunction

    function void flag(string msg);
        if (errors < 10)
            $display("%s", msg);
        errors++;
    endfunction

    function void compare(string name, int exp_v, int got_v);
        if (exp_v != got_v)
            flag($sformatf("%s mismatch: expected %0d, got %0d", name, exp_v, got_v));
    endfunction

    function void check_beat(shaper_beat_t got);
        shaper_beat_t want;
        if (expected_beats.size() == 0)
        begin
            flag($sformatf("unexpected result beat: motor %0d timed_out %0d",
                           got.motor, got.timed_out));
            return;
        end
        want = expected_beats.pop_front();
        compare("motor_pulse", int'(want.motor), int'(got.motor));
        compare("rudder_pulse", int'(want.rudder), int'(got.rudder));
        compare("starboard_pulse", int'(want.stbd), int'(got.stbd));
        compare("port_pulse", int'(want.port), int'(got.port));
        compare("link_timeout_out", int'(want.link_timeout), int'(got.link_timeout));
        compare("led_out", int'(want.led), int'(got.led));
        compare("timed_out", int'(want.timed_out), int'(got.timed_out));
    endfunction
endclass

module servo_command_shaper_test;
    import scs_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    scs_in_if item_if ();
    scs_out_if result_if ();

    servo_command_shaper u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_if),
        .result    (result_if)
    );

    shaper_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int hold_cycles;
    logic [TIMEOUT_W-1:0] clock_us;
    logic [TIMEOUT_W-1:0] last_cmd_sent;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_if.valid && item_if.ready)
                sb.note_item('{func: item_if.func, now_us: item_if.now_us,
                               present_mask: item_if.present_mask,
                               motor_pct: item_if.motor_percent,
                               rudder_pct: item_if.rudder_percent,
                               stbd_pct: item_if.starboard_percent,
                               port_pct: item_if.port_percent,
                               link_timeout: item_if.link_timeout_in,
                               led: item_if.led_in});
            if (result_if.valid && result_if.ready)
                sb.check_beat('{motor: result_if.motor_pulse, rudder: result_if.rudder_pulse,
                                stbd: result_if.starboard_pulse, port: result_if.port_pulse,
                                link_timeout: result_if.link_timeout_out,
                                led: result_if.led_out, timed_out: result_if.timed_out});
        end
    end

    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                result_if.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                result_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    function automatic shaper_item_t build(logic func, logic [TIMEOUT_W-1:0] now,
                                           logic [MASK_W-1:0] mask, logic [7:0] m,
                                           logic [7:0] r, logic [7:0] s, logic [7:0] p,
                                           logic [7:0] link, logic led);
        shaper_item_t it;
        it.func = func;
        it.now_us = now;
        it.present_mask = mask;
        it.motor_pct = m;
        it.rudder_pct = r;
        it.stbd_pct = s;
        it.port_pct = p;
        it.link_timeout = link;
        it.led = led;
        return it;
    endfunction

    function automatic logic [7:0] pct_value();
        int v;
        if ($urandom_range(99) < 15)
            return 8'($urandom);
        v = int'($urandom_range(200)) - 100;
        return v[7:0];
    endfunction

    function automatic logic [35:0] random_bounds(bit well_formed);
        logic [63:0] raw;
        logic [11:0] lower;
        logic [11:0] center;
        logic [11:0] upper;
        raw = {$urandom, $urandom};
        if (!well_formed)
            return raw[35:0];
        lower = 12'($urandom_range(1500, 300));
        center = lower + 12'($urandom_range(600));
        upper = center + 12'($urandom_range(900));
        return {upper, center, lower};
    endfunction

    function automatic shaper_item_t next_item();
        shaper_item_t it;
        logic [TIMEOUT_W-1:0] cap;
        it.present_mask = ($urandom_range(3) == 0) ? 6'h3F : 6'($urandom);
        it.motor_pct = pct_value();
        it.rudder_pct = pct_value();
        it.stbd_pct = pct_value();
        it.port_pct = pct_value();
        it.link_timeout = 8'($urandom);
        it.led = 1'($urandom);
        if ($urandom_range(99) < 8)
        begin
            it.func = 1'($urandom);
            it.now_us = 48'({$urandom, $urandom});
        end
        else
        begin
            it.func = ($urandom_range(99) < 45) ? FUNC_COMMAND : FUNC_TICK;
            if (it.func == FUNC_TICK && $urandom_range(9) == 0)
            begin
                clock_us = last_cmd_sent + sb.timeout_us + 48'($urandom_range(1));
            end
            else
            begin
                cap = sb.timeout_us / 3;
                if (cap > 48'd100000)
                    cap = 48'd100000;
                clock_us = clock_us + 48'($urandom_range(32'(cap)));
            end
            it.now_us = clock_us;
        end
        clock_us = it.now_us;
        if (it.func == FUNC_COMMAND)
            last_cmd_sent = it.now_us;
        return it;
    endfunction

    task automatic send_item(input shaper_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.func <= it.func;
        item_if.now_us <= it.now_us;
        item_if.present_mask <= it.present_mask;
        item_if.motor_percent <= it.motor_pct;
        item_if.rudder_percent <= it.rudder_pct;
        item_if.starboard_percent <= it.stbd_pct;
        item_if.port_percent <= it.port_pct;
        item_if.link_timeout_in <= it.link_timeout;
        item_if.led_in <= it.led;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
    endtask

    task automatic wait_results(input int extra);
        item_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_beats.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_settings(input int sel);
        logic [CFG_W-1:0] val [8];
        val[CFG_RUDDER_BOUNDS] = CFG_W'(random_bounds(1'b1));
        val[CFG_STBD_BOUNDS] = CFG_W'(random_bounds(1'b1));
        val[CFG_PORT_BOUNDS] = CFG_W'(random_bounds(1'b1));
        case (sel)
            0:
            begin
                val[CFG_MOTOR_STEP] = CFG_W'(20);
                val[CFG_MOTOR_RSTEP] = CFG_W'(100);
                val[CFG_FORWARD_START] = CFG_W'(1500);
                val[CFG_REVERSE_START] = CFG_W'(1500);
                val[CFG_TIMEOUT] = CFG_W'(20000);
                val[CFG_RUDDER_BOUNDS] = CFG_W'({12'd1900, 12'd1500, 12'd1100});
                val[CFG_STBD_BOUNDS] = CFG_W'({12'd1900, 12'd1500, 12'd1100});
                val[CFG_PORT_BOUNDS] = CFG_W'({12'd1900, 12'd1500, 12'd1100});
            end
            1:
            begin
                val[CFG_MOTOR_STEP] = CFG_W'(1);
                val[CFG_MOTOR_RSTEP] = CFG_W'(1);
                val[CFG_FORWARD_START] = CFG_W'(1500);
                val[CFG_REVERSE_START] = CFG_W'(0);
                val[CFG_TIMEOUT] = CFG_W'(1);
            end
            2:
            begin
                val[CFG_MOTOR_STEP] = CFG_W'(400);
                val[CFG_MOTOR_RSTEP] = CFG_W'(800);
                val[CFG_FORWARD_START] = CFG_W'(4095);
                val[CFG_REVERSE_START] = CFG_W'(1500);
                val[CFG_TIMEOUT] = 48'hFFFF_FFFF_FFFF;
                val[CFG_RUDDER_BOUNDS] = CFG_W'(36'hF_FFFF_FFFF);
                val[CFG_STBD_BOUNDS] = CFG_W'(36'hF_FFFF_FFFF);
                val[CFG_PORT_BOUNDS] = CFG_W'(36'hF_FFFF_FFFF);
            end
            3:
            begin
                val[CFG_MOTOR_STEP] = CFG_W'(0);
                val[CFG_MOTOR_RSTEP] = CFG_W'(0);
                val[CFG_FORWARD_START] = CFG_W'(1600);
                val[CFG_REVERSE_START] = CFG_W'(1400);
                val[CFG_TIMEOUT] = CFG_W'(50000);
                val[CFG_RUDDER_BOUNDS] = '0;
                val[CFG_STBD_BOUNDS] = CFG_W'(random_bounds(1'b0));
            end
            default:
            begin
                val[CFG_MOTOR_STEP] = CFG_W'($urandom_range(511));
                val[CFG_MOTOR_RSTEP] = CFG_W'($urandom_range(1023));
                val[CFG_FORWARD_START] = CFG_W'($urandom_range(4095));
                val[CFG_REVERSE_START] = CFG_W'($urandom_range(2047));
                val[CFG_TIMEOUT] = CFG_W'($urandom_range(300000, 1000));
                val[CFG_RUDDER_BOUNDS] = CFG_W'(random_bounds(1'($urandom)));
                val[CFG_STBD_BOUNDS] = CFG_W'(random_bounds(1'($urandom)));
                val[CFG_PORT_BOUNDS] = CFG_W'(random_bounds(1'($urandom)));
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(cfg_index_t'(i), val[i]);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int ph;
        int n;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_if.valid = 1'b0;
        item_if.func = FUNC_COMMAND;
        item_if.now_us = '0;
        item_if.present_mask = '0;
        item_if.motor_percent = '0;
        item_if.rudder_percent = '0;
        item_if.starboard_percent = '0;
        item_if.port_percent = '0;
        item_if.link_timeout_in = '0;
        item_if.led_in = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        clock_us = '0;
        last_cmd_sent = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no command yet: a tick at any age stays live
        send_item(build(FUNC_TICK, 48'hFFFF_FFFF_FFFF, 6'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h00, 1'b0));
        // saturating percents, every field present
        send_item(build(FUNC_COMMAND, 48'd1000, 6'h3F, 8'h7F, 8'h80, 8'h64, 8'h9C,
                        8'hFF, 1'b0));
        repeat (3) send_item(build(FUNC_TICK, 48'd1000, 6'h3F, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 1'b1));
        // reverse the motor: reverse step above neutral, forward step below
        send_item(build(FUNC_COMMAND, 48'd2000, 6'h01, 8'h9C, 8'h7F, 8'h7F, 8'h7F,
                        8'h00, 1'b1));
        repeat (3) send_item(build(FUNC_TICK, 48'd2000, 6'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 1'b0));
        send_item(build(FUNC_COMMAND, 48'd3000, 6'h3E, 8'h00, 8'h01, 8'hFF, 8'h00,
                        8'h00, 1'b1));
        // age equal to the timeout is still live, one more is stale
        send_item(build(FUNC_TICK, 48'd5003000, 6'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h00, 1'b0));
        send_item(build(FUNC_TICK, 48'd5003001, 6'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h00, 1'b0));
        // time wraps between command and tick
        send_item(build(FUNC_COMMAND, 48'hFFFF_FFFF_FF00, 6'h00, 8'h00, 8'h00, 8'h00,
                        8'h00, 8'h00, 1'b0));
        send_item(build(FUNC_TICK, 48'h100, 6'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h00, 1'b0));
        send_item(build(FUNC_COMMAND, 48'h100, 6'h31, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h55, 1'b0));
        repeat (3) send_item(build(FUNC_TICK, 48'h100, 6'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 1'b0));
        send_item(build(FUNC_COMMAND, 48'h200, 6'h20, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h00, 1'b1));
        send_item(build(FUNC_TICK, 48'h200, 6'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h00, 1'b0));
        clock_us = 48'h200;
        last_cmd_sent = 48'h200;

        for (ph = 0; ph < 8; ph++)
        begin
            wait_results(8);
            apply_settings(ph);
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 50;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 50;
                end
                default:
                begin
                    send_idle_pct = 18;
                    stall_pct = 18;
                end
            endcase
            for (n = 0; n < 66; n++)
            begin
                if (n == 33)
                begin
                    if (ph % 2 == 0)
                        hold_cycles = 200;
                    else
                        wait_results(0);
                end
                send_item(next_item());
            end
        end

        wait_results(20);
        if (sb.errors == 0 && sb.expected_beats.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
